>>> hdl/mrqm_pkg.sv
`default_nettype none

package mrqm_pkg;

   // Output mode register codes
   localparam logic [1:0] MODE_QUAD    = 2'd0;
   localparam logic [1:0] MODE_TRI     = 2'd1;
   localparam logic [1:0] MODE_INDEXED = 2'd2;

   // Record kind codes on the result channel
   localparam logic [1:0] KIND_QUAD     = 2'd0;
   localparam logic [1:0] KIND_VERTEX   = 2'd1;
   localparam logic [1:0] KIND_INDEX    = 2'd2;
   localparam logic [1:0] KIND_OVERFLOW = 2'd3;

   localparam int         MIN_SYMBOL = 21;
   localparam int         CAP_REG_W  = 11;
   localparam logic [7:0] LUMA_LIGHT = 8'd255;
   localparam logic [7:0] LUMA_DARK  = 8'd0;

   // Slot numbers inside one quad's record burst
   localparam logic [3:0] SLOT_FIRST_INDEX = 4'd4;
   localparam logic [3:0] SLOT_LAST_TRI    = 4'd5;
   localparam logic [3:0] SLOT_LAST_INDEX  = 4'd9;

   // Triangle list: TL, TR, BL, BL, TR, BR
   function automatic logic tri_x_right(input logic [3:0] slot);
      return (slot == 4'd1) || (slot == 4'd4) || (slot == 4'd5);
   endfunction

   function automatic logic tri_y_bottom(input logic [3:0] slot);
      return (slot == 4'd2) || (slot == 4'd3) || (slot == 4'd5);
   endfunction

   // Indexed vertices: TL, TR, BR, BL
   function automatic logic ind_x_right(input logic [3:0] slot);
      return (slot == 4'd1) || (slot == 4'd2);
   endfunction

   function automatic logic ind_y_bottom(input logic [3:0] slot);
      return (slot == 4'd2) || (slot == 4'd3);
   endfunction

   // Index list 0,1,3,3,1,2 on slots four to nine
   function automatic logic [1:0] index_offset(input logic [3:0] slot);
      logic [1:0] ofs;
      case (slot)
         4'd4:    ofs = 2'd0;
         4'd5:    ofs = 2'd1;
         4'd6:    ofs = 2'd3;
         4'd7:    ofs = 2'd3;
         4'd8:    ofs = 2'd1;
         4'd9:    ofs = 2'd2;
         default: ofs = 2'd0;
      endcase
      return ofs;
   endfunction

endpackage

`default_nettype wire

>>> hdl/mrqm_req_if.sv
`default_nettype none

interface mrqm_req_if;
   logic valid;
   logic ready;
   logic dark;

   modport source (output valid, output dark, input ready);
   modport sink   (input valid, input dark, output ready);
endinterface

`default_nettype wire

>>> hdl/mrqm_rsp_if.sv
`default_nettype none

interface mrqm_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         record_kind;
   logic signed [16:0] left_or_x;
   logic signed [16:0] top_or_y;
   logic signed [16:0] right_edge;
   logic signed [16:0] bottom_edge;
   logic               is_dark;
   logic [7:0]         luma;
   logic [31:0]        index_value;
   logic               frame_end;
   logic               last;

   modport source (output valid, output record_kind, output left_or_x, output top_or_y,
                   output right_edge, output bottom_edge, output is_dark, output luma,
                   output index_value, output frame_end, output last, input ready);
   modport sink   (input valid, input record_kind, input left_or_x, input top_or_y,
                   input right_edge, input bottom_edge, input is_dark, input luma,
                   input index_value, input frame_end, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/module_runs_to_quad_mesh_top.sv
`default_nettype none

// Channel   Direction  Handshake      Payload
// req_ch    in         valid/ready    dark (one module bit, raster order)
// rsp_ch    out        valid/ready    record_kind, edges/vertex, is_dark, luma, index, flags
// csr_*     in         csr_we only    csr_index selects register, csr_wdata value
//
// One module bit per cycle enters; its quad geometry is computed on the way into the
// record register. A quad yields 1, 6 or 10 records (quad, triangle or indexed mode),
// one per cycle while rsp_ch is ready; input stalls while a burst drains, except in its
// final cycle. Reset is synchronous and clears the raster position, run tracking, quad
// count and overflow flag; registers take defaults.

module module_runs_to_quad_mesh_top
   import mrqm_pkg::*;
#(
   parameter int MAX_SYMBOL = 177,
   parameter int MAX_QUADS  = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mrqm_req_if.sink         req_ch,
   mrqm_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int SIZE_W = $clog2(MAX_SYMBOL + 1);
   localparam int CNT_W  = $clog2(MAX_SYMBOL);
   localparam int QW     = $clog2(MAX_QUADS + 1);
   localparam int CAPW   = (QW > CAP_REG_W) ? QW : CAP_REG_W;
   localparam int PW     = SIZE_W + 8;
   localparam int CW     = SIZE_W + 16;

   typedef enum logic [2:0] {
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_MODULE_PIXELS, REG_QUIET_MODULES,
      REG_SYMBOL_MODULES, REG_OUTPUT_MODE, REG_BASE_VERTEX, REG_QUAD_CAPACITY
   } reg_index_type;

   typedef enum logic [1:0] {FMT_QUAD, FMT_TRI, FMT_INDEXED, FMT_OVERFLOW} fmt_type;

   typedef struct packed {
      fmt_type     fmt;
      logic        dark;
      logic        frame_end;
      logic [16:0] left;
      logic [16:0] top;
      logic [16:0] right;
      logic [16:0] bottom;
      logic [31:0] first_vertex;
   } desc_type;

   // Configuration registers
   logic [15:0]          origin_x_ff, origin_y_ff;
   logic [6:0]           mpix_ff;
   logic [4:0]           quiet_ff;
   logic [7:0]           symbol_ff;
   logic [1:0]           mode_ff;
   logic [31:0]          base_vertex_ff;
   logic [CAP_REG_W-1:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         mpix_ff        <= 7'd4;
         quiet_ff       <= 5'd4;
         symbol_ff      <= 8'd21;
         mode_ff        <= MODE_QUAD;
         base_vertex_ff <= '0;
         capacity_ff    <= CAP_REG_W'(1024);
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_ORIGIN_X:       origin_x_ff    <= csr_wdata[15:0];
            REG_ORIGIN_Y:       origin_y_ff    <= csr_wdata[15:0];
            REG_MODULE_PIXELS:  mpix_ff        <= csr_wdata[6:0];
            REG_QUIET_MODULES:  quiet_ff       <= csr_wdata[4:0];
            REG_SYMBOL_MODULES: symbol_ff      <= csr_wdata[7:0];
            REG_OUTPUT_MODE:    mode_ff        <= csr_wdata[1:0];
            REG_BASE_VERTEX:    base_vertex_ff <= csr_wdata;
            REG_QUAD_CAPACITY:  capacity_ff    <= csr_wdata[CAP_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Raster and run state
   logic [CNT_W-1:0] column_ff, column_in, row_ff, row_in, run_begin_ff, run_begin_in;
   logic             in_run_ff, in_run_in, overflowed_ff, overflowed_in;
   logic [QW-1:0]    quads_ff, quads_in;

   // Output record register
   logic     desc_valid_ff, desc_valid_in;
   logic [3:0] rec_cnt_ff, rec_cnt_in;
   desc_type desc_ff, desc_in;

   logic req_acc, rsp_acc, rsp_done, rec_last_c;
   logic [3:0] rec_max_c;

   // Saturated symbol size and frame position
   logic [SIZE_W-1:0] size_c;
   logic              last_col, last_row;

   always_comb begin
      if (int'(symbol_ff) < MIN_SYMBOL)       size_c = SIZE_W'(MIN_SYMBOL);
      else if (int'(symbol_ff) > MAX_SYMBOL)  size_c = SIZE_W'(MAX_SYMBOL);
      else                                    size_c = SIZE_W'(symbol_ff);
   end

   assign last_col = SIZE_W'(column_ff) >= (size_c - SIZE_W'(1));
   assign last_row = SIZE_W'(row_ff) >= (size_c - SIZE_W'(1));

   // Geometry: small products, then sums
   logic [CNT_W-1:0]  rb_c;
   logic [CNT_W:0]    colr_c;
   logic [SIZE_W:0]   edge_mod_c;
   logic [11:0]       qm_c;
   logic [PW-1:0]     rowm_c, rbm_c, colm_c, edge_c;
   logic [CW-1:0]     ox_c, oy_c, sl_c, top_c;
   logic [CW-1:0]     bg_r_c, bg_b_c, dk_l_c, dk_r_c, dk_b_c;

   assign rb_c       = in_run_ff ? run_begin_ff : column_ff;
   assign colr_c     = req_ch.dark ? ((CNT_W + 1)'(column_ff) + (CNT_W + 1)'(1))
                                   : (CNT_W + 1)'(column_ff);
   assign edge_mod_c = (SIZE_W + 1)'(size_c) + (SIZE_W + 1)'({quiet_ff, 1'b0});
   assign qm_c       = 12'(quiet_ff) * 12'(mpix_ff);
   assign rowm_c     = PW'(row_ff) * PW'(mpix_ff);
   assign rbm_c      = PW'(rb_c) * PW'(mpix_ff);
   assign colm_c     = PW'(colr_c) * PW'(mpix_ff);
   assign edge_c     = PW'(edge_mod_c) * PW'(mpix_ff);

   assign ox_c   = CW'($signed(origin_x_ff));
   assign oy_c   = CW'($signed(origin_y_ff));
   assign sl_c   = ox_c + CW'(qm_c);
   assign top_c  = oy_c + CW'(qm_c) + CW'(rowm_c);
   assign bg_r_c = ox_c + CW'(edge_c);
   assign bg_b_c = oy_c + CW'(edge_c);
   assign dk_l_c = sl_c + CW'(rbm_c);
   assign dk_r_c = sl_c + CW'(colm_c);
   assign dk_b_c = top_c + CW'(mpix_ff);

   // Quad decision and capacity check
   logic            bg_emit, run_emit, quad_emit, cap_hit, load_desc;
   logic [CAPW-1:0] cap_c;

   assign bg_emit   = (column_ff == '0) && (row_ff == '0);
   assign run_emit  = req_ch.dark ? last_col : in_run_ff;
   assign quad_emit = bg_emit || run_emit;
   assign cap_c     = (int'(capacity_ff) > MAX_QUADS) ? CAPW'(MAX_QUADS) : CAPW'(capacity_ff);
   assign cap_hit   = CAPW'(quads_ff) >= cap_c;
   assign load_desc = req_acc && quad_emit && !overflowed_ff;

   // Handshakes
   assign rsp_acc      = rsp_ch.valid && rsp_ch.ready;
   assign rsp_done     = rsp_acc && rec_last_c;
   assign req_ch.ready = !desc_valid_ff || rsp_done;
   assign req_acc      = req_ch.valid && req_ch.ready;

   // Next raster and run state
   always_comb begin
      column_in     = column_ff;
      row_in        = row_ff;
      run_begin_in  = run_begin_ff;
      in_run_in     = in_run_ff;
      quads_in      = quads_ff;
      overflowed_in = overflowed_ff;
      if (req_acc) begin
         if (req_ch.dark) begin
            if (!in_run_ff) begin
               in_run_in    = 1'b1;
               run_begin_in = column_ff;
            end
         end else begin
            in_run_in = 1'b0;
         end
         if (quad_emit && !overflowed_ff) begin
            if (cap_hit) overflowed_in = 1'b1;
            else         quads_in      = quads_ff + QW'(1);
         end
         if (last_col) begin
            in_run_in = 1'b0;
            column_in = '0;
            if (last_row) begin
               row_in        = '0;
               quads_in      = '0;
               overflowed_in = 1'b0;
            end else begin
               row_in = row_ff + CNT_W'(1);
            end
         end else begin
            column_in = column_ff + CNT_W'(1);
         end
      end
   end

   // Next record register contents
   always_comb begin
      desc_valid_in = desc_valid_ff;
      rec_cnt_in    = rec_cnt_ff;
      desc_in       = desc_ff;
      if (load_desc) begin
         desc_valid_in        = 1'b1;
         rec_cnt_in           = '0;
         desc_in.dark         = !bg_emit;
         desc_in.frame_end    = last_col && last_row;
         desc_in.left         = bg_emit ? ox_c[16:0]   : dk_l_c[16:0];
         desc_in.top          = bg_emit ? oy_c[16:0]   : top_c[16:0];
         desc_in.right        = bg_emit ? bg_r_c[16:0] : dk_r_c[16:0];
         desc_in.bottom       = bg_emit ? bg_b_c[16:0] : dk_b_c[16:0];
         desc_in.first_vertex = base_vertex_ff + 32'({quads_ff, 2'b00});
         if (cap_hit) begin
            desc_in.fmt = FMT_OVERFLOW;
         end else begin
            case (mode_ff)
               MODE_TRI:     desc_in.fmt = FMT_TRI;
               MODE_INDEXED: desc_in.fmt = FMT_INDEXED;
               default:      desc_in.fmt = FMT_QUAD;
            endcase
         end
      end else if (rsp_done) begin
         desc_valid_in = 1'b0;
      end else if (rsp_acc) begin
         rec_cnt_in = rec_cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         run_begin_ff  <= '0;
         in_run_ff     <= 1'b0;
         quads_ff      <= '0;
         overflowed_ff <= 1'b0;
         desc_valid_ff <= 1'b0;
         rec_cnt_ff    <= '0;
      end else begin
         column_ff     <= column_in;
         row_ff        <= row_in;
         run_begin_ff  <= run_begin_in;
         in_run_ff     <= in_run_in;
         quads_ff      <= quads_in;
         overflowed_ff <= overflowed_in;
         desc_valid_ff <= desc_valid_in;
         rec_cnt_ff    <= rec_cnt_in;
      end
      desc_ff <= desc_in;
   end

   // Record selection from the held quad
   always_comb begin
      case (desc_ff.fmt)
         FMT_TRI:     rec_max_c = SLOT_LAST_TRI;
         FMT_INDEXED: rec_max_c = SLOT_LAST_INDEX;
         default:     rec_max_c = 4'd0;
      endcase
   end

   assign rec_last_c = rec_cnt_ff == rec_max_c;

   always_comb begin
      logic x_right, y_bottom;
      x_right  = 1'b0;
      y_bottom = 1'b0;
      rsp_ch.valid       = desc_valid_ff;
      rsp_ch.record_kind = KIND_QUAD;
      rsp_ch.left_or_x   = '0;
      rsp_ch.top_or_y    = '0;
      rsp_ch.right_edge  = '0;
      rsp_ch.bottom_edge = '0;
      rsp_ch.is_dark     = desc_ff.dark;
      rsp_ch.luma        = '0;
      rsp_ch.index_value = '0;
      rsp_ch.frame_end   = desc_ff.frame_end;
      rsp_ch.last        = rec_last_c;
      case (desc_ff.fmt)
         FMT_QUAD: begin
            rsp_ch.left_or_x   = desc_ff.left;
            rsp_ch.top_or_y    = desc_ff.top;
            rsp_ch.right_edge  = desc_ff.right;
            rsp_ch.bottom_edge = desc_ff.bottom;
         end
         FMT_TRI: begin
            x_right            = tri_x_right(rec_cnt_ff);
            y_bottom           = tri_y_bottom(rec_cnt_ff);
            rsp_ch.record_kind = KIND_VERTEX;
            rsp_ch.left_or_x   = x_right ? desc_ff.right : desc_ff.left;
            rsp_ch.top_or_y    = y_bottom ? desc_ff.bottom : desc_ff.top;
            rsp_ch.luma        = desc_ff.dark ? LUMA_DARK : LUMA_LIGHT;
         end
         FMT_INDEXED: begin
            if (rec_cnt_ff < SLOT_FIRST_INDEX) begin
               x_right            = ind_x_right(rec_cnt_ff);
               y_bottom           = ind_y_bottom(rec_cnt_ff);
               rsp_ch.record_kind = KIND_VERTEX;
               rsp_ch.left_or_x   = x_right ? desc_ff.right : desc_ff.left;
               rsp_ch.top_or_y    = y_bottom ? desc_ff.bottom : desc_ff.top;
               rsp_ch.luma        = desc_ff.dark ? LUMA_DARK : LUMA_LIGHT;
            end else begin
               rsp_ch.record_kind = KIND_INDEX;
               rsp_ch.index_value = desc_ff.first_vertex + 32'(index_offset(rec_cnt_ff));
            end
         end
         default: begin
            rsp_ch.record_kind = KIND_OVERFLOW;
            rsp_ch.is_dark     = 1'b0;
         end
      endcase
   end

`ifndef SYNTH
   // Burst counter never runs past the burst length
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      desc_valid_ff |-> (rec_cnt_ff <= rec_max_c))
      else $error("record counter past end of burst");

   // A new bit is taken over a busy record register only as its burst finishes
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_acc && desc_valid_ff) |-> rsp_done)
      else $error("input accepted over an unfinished burst");

   // Overflow status is a single record
   a_ovf_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.record_kind == KIND_OVERFLOW)) |-> rsp_ch.last)
      else $error("overflow record not last");

   // Frame end clears position, quad count and overflow
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last_col && last_row) |=>
         ((column_ff == '0) && (row_ff == '0) && (quads_ff == '0) && !overflowed_ff))
      else $error("frame state not cleared at frame end");
`endif

endmodule

`default_nettype wire
